>>> hw/rtl/arht_pkg.sv
// ============================================================================
// Address range handler table package
// Shared widths, codes and structures of the address range handler table.
// ============================================================================
package arht_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 64;
    localparam int TAG_W    = 8;
    localparam int VCPU_W   = 8;
    localparam int SYN_W    = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR    = 2'd0,
        KIND_REGISTER = 2'd1,
        KIND_LOOKUP   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_INVALID = 3'd2,
        STAT_OVERLAP = 3'd3,
        STAT_NOMATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_size;
        logic [TAG_W-1:0]  handler_tag;
        logic [ADDR_W-1:0] fault_addr;
        logic [VCPU_W-1:0] vcpu_number;
        logic [SYN_W-1:0]  fault_syndrome;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  matched_tag;
        logic [ADDR_W-1:0] offset;
        logic [VCPU_W-1:0] vcpu_out;
        logic [SYN_W-1:0]  syndrome_out;
    } res_t;

    typedef struct packed {
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic [TAG_W-1:0]  range_tag;
    } entry_t;

endpackage

>>> hw/rtl/arht_mem.sv
// ============================================================================
// Address range table memory
// One write port and one read port with registered read data.
// ============================================================================
module arht_mem #(
    parameter int ENTRIES = arht_pkg::ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  arht_pkg::entry_t    wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output arht_pkg::entry_t    rd_data
);

    arht_pkg::entry_t mem [ENTRIES];
    arht_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/arht_ctrl.sv
// ============================================================================
// Address range table controller
// Decodes each request, scans the stored ranges one entry per cycle and
// appends accepted registrations to the table memory.
// ============================================================================
module arht_ctrl #(
    parameter int ENTRIES = arht_pkg::ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  arht_pkg::req_t      req,
    output logic [IDX_W-1:0]    rd_addr,
    input  arht_pkg::entry_t    rd_data,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output arht_pkg::entry_t    wr_data,
    output logic                res_valid,
    input  logic                res_ready,
    output arht_pkg::res_t      res
);

    arht_pkg::state_t state_reg;
    arht_pkg::state_t state_next;

    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    logic [arht_pkg::KIND_W-1:0] kind_reg;
    logic [arht_pkg::KIND_W-1:0] kind_next;
    logic [arht_pkg::ADDR_W-1:0] base_reg;
    logic [arht_pkg::ADDR_W-1:0] base_next;
    logic [arht_pkg::ADDR_W-1:0] last_reg;
    logic [arht_pkg::ADDR_W-1:0] last_next;
    logic [arht_pkg::TAG_W-1:0]  tag_reg;
    logic [arht_pkg::TAG_W-1:0]  tag_next;
    logic [arht_pkg::ADDR_W-1:0] addr_reg;
    logic [arht_pkg::ADDR_W-1:0] addr_next;
    arht_pkg::res_t              res_reg;
    arht_pkg::res_t              res_next;

    logic                        accept;
    logic [arht_pkg::ADDR_W:0]   sum;
    logic                        req_bad;
    logic                        full;
    logic                        empty;
    logic                        is_reg;
    logic                        ovl;
    logic                        hit;
    logic                        match;
    logic                        last_idx;
    logic                        start_scan;
    logic                        write_now;
    logic                        write_end;

    assign accept  = in_valid && !in_stall;
    assign sum     = {1'b0, req.region_base} + {1'b0, req.region_size};
    assign req_bad = (req.region_size == '0) || (req.handler_tag == '0) ||
                     sum[arht_pkg::ADDR_W];
    assign full    = count_reg >= IDX_W'(ENTRIES - 1);
    assign empty   = count_reg == '0;

    assign is_reg   = kind_reg == arht_pkg::KIND_REGISTER;
    assign ovl      = (base_reg < rd_data.range_end) && (last_reg > rd_data.range_start);
    assign hit      = (addr_reg >= rd_data.range_start) && (addr_reg < rd_data.range_end);
    assign match    = is_reg ? ovl : hit;
    assign last_idx = idx_reg == (count_reg - 1'b1);

    assign start_scan = ((req.kind == arht_pkg::KIND_REGISTER) && !full && !req_bad &&
                         !empty) ||
                        ((req.kind == arht_pkg::KIND_LOOKUP) && !empty);
    assign write_now  = accept && (req.kind == arht_pkg::KIND_REGISTER) && !full &&
                        !req_bad && empty;
    assign write_end  = (state_reg == arht_pkg::ST_SCAN) && is_reg && !ovl && last_idx;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arht_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = start_scan ? arht_pkg::ST_SCAN : arht_pkg::ST_DONE;
                end
            end
            arht_pkg::ST_SCAN:
            begin
                if (match || last_idx)
                begin
                    state_next = arht_pkg::ST_DONE;
                end
            end
            arht_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = arht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arht_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        res_valid = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = count_reg;
        wr_data   = '{range_start: base_reg, range_end: last_reg, range_tag: tag_reg};
        unique case (state_reg)
            arht_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                wr_en    = write_now;
                wr_data  = '{range_start: req.region_base,
                             range_end:   sum[arht_pkg::ADDR_W-1:0],
                             range_tag:   req.handler_tag};
            end
            arht_pkg::ST_SCAN:
            begin
                rd_addr = idx_reg + 1'b1;
                wr_en   = write_end;
            end
            arht_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        base_next  = base_reg;
        last_next  = last_reg;
        tag_next   = tag_reg;
        addr_next  = addr_reg;
        res_next   = res_reg;
        if (accept)
        begin
            kind_next = req.kind;
            base_next = req.region_base;
            last_next = sum[arht_pkg::ADDR_W-1:0];
            tag_next  = req.handler_tag;
            addr_next = req.fault_addr;
            idx_next  = '0;
            res_next  = '{status: arht_pkg::STAT_OK, matched_tag: '0, offset: '0,
                          vcpu_out: '0, syndrome_out: '0};
            unique case (req.kind)
                arht_pkg::KIND_CLEAR:
                begin
                    count_next = '0;
                end
                arht_pkg::KIND_REGISTER:
                begin
                    if (full)
                    begin
                        res_next.status = arht_pkg::STAT_FULL;
                    end
                    else if (req_bad)
                    begin
                        res_next.status = arht_pkg::STAT_INVALID;
                    end
                    else if (empty)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                arht_pkg::KIND_LOOKUP:
                begin
                    res_next.status       = arht_pkg::STAT_NOMATCH;
                    res_next.vcpu_out     = req.vcpu_number;
                    res_next.syndrome_out = req.fault_syndrome;
                end
                default:
                begin
                    res_next.status = arht_pkg::STAT_INVALID;
                end
            endcase
        end
        else if (state_reg == arht_pkg::ST_SCAN)
        begin
            idx_next = idx_reg + 1'b1;
            if (is_reg)
            begin
                if (ovl)
                begin
                    res_next.status = arht_pkg::STAT_OVERLAP;
                end
                else if (last_idx)
                begin
                    res_next.status = arht_pkg::STAT_OK;
                    count_next      = count_reg + 1'b1;
                end
            end
            else if (hit)
            begin
                res_next.status      = arht_pkg::STAT_OK;
                res_next.matched_tag = rd_data.range_tag;
                res_next.offset      = addr_reg - rd_data.range_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arht_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        base_reg <= base_next;
        last_reg <= last_next;
        tag_reg  <= tag_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

>>> hw/rtl/address_range_handler_table.sv
// ============================================================================
// Address range handler table
// Stores half-open address ranges with handler tags and resolves lookups.
// ============================================================================
// The block handles one request at a time. A clear, a refused registration,
// a registration into an empty table, a lookup in an empty table, or an
// unknown kind goes from the idle state straight to the done state with no
// scan. A registration or lookup that scans the table reads one stored range
// per cycle from the table memory; a lookup stops early at the first range
// that holds the address. A finished result sits in an output register, so
// the next request can be taken while it waits. While that register stays
// full and stalled, a later result waits and holds the input stalled.
module address_range_handler_table #(
    parameter int ENTRIES = arht_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [arht_pkg::KIND_W-1:0]     kind,
    input  logic [arht_pkg::ADDR_W-1:0]     region_base,
    input  logic [arht_pkg::ADDR_W-1:0]     region_size,
    input  logic [arht_pkg::TAG_W-1:0]      handler_tag,
    input  logic [arht_pkg::ADDR_W-1:0]     fault_addr,
    input  logic [arht_pkg::VCPU_W-1:0]     vcpu_number,
    input  logic [arht_pkg::SYN_W-1:0]      fault_syndrome,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [arht_pkg::STATUS_W-1:0]   status,
    output logic [arht_pkg::TAG_W-1:0]      matched_tag,
    output logic [arht_pkg::ADDR_W-1:0]     offset,
    output logic [arht_pkg::VCPU_W-1:0]     vcpu_out,
    output logic [arht_pkg::SYN_W-1:0]      syndrome_out
);

    localparam int IDX_W = $clog2(ENTRIES);

    arht_pkg::req_t     req;
    arht_pkg::res_t     res;
    arht_pkg::entry_t   rd_data;
    arht_pkg::entry_t   wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    logic               res_valid;
    logic               res_ready;
    logic               load;

    logic               out_valid_reg;
    logic               out_valid_next;
    arht_pkg::res_t     out_res_reg;

    assign req = '{kind:           kind,
                   region_base:    region_base,
                   region_size:    region_size,
                   handler_tag:    handler_tag,
                   fault_addr:     fault_addr,
                   vcpu_number:    vcpu_number,
                   fault_syndrome: fault_syndrome};

    arht_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req       (req),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    arht_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign matched_tag  = out_res_reg.matched_tag;
    assign offset       = out_res_reg.offset;
    assign vcpu_out     = out_res_reg.vcpu_out;
    assign syndrome_out = out_res_reg.syndrome_out;

endmodule
